// ----- sv/yenc_stream_decoder_unit_defines.svh -----
// ----------------------------------------------------------------------------
// yEnc stream decoder assertion macros
// Shared assertion forms for the decoder top level.
// ----------------------------------------------------------------------------
`ifndef YENC_STREAM_DECODER_UNIT_DEFINES_SVH
`define YENC_STREAM_DECODER_UNIT_DEFINES_SVH

// same-cycle implication
`define YSD_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ysd: implication check failed");

// next-cycle implication
`define YSD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ysd: next-cycle check failed");

`endif

// ----- sv/ysd_pkg.sv -----
// ----------------------------------------------------------------------------
// ysd_pkg
// Types, character codes and helper functions of the yEnc stream decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ysd_pkg;

  typedef enum logic [1:0] {
    PH_PROLOG = 2'd0,
    PH_DATA   = 2'd1,
    PH_EPILOG = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    LP_MID   = 2'd0,
    LP_START = 2'd1,
    LP_EQ    = 2'd2,
    LP_KEY   = 2'd3
  } lpos_e;

  typedef enum logic [1:0] {
    KW_NONE  = 2'd0,
    KW_BEGIN = 2'd1,
    KW_PART  = 2'd2,
    KW_END   = 2'd3
  } kw_e;

  typedef enum logic {
    KIND_DATA    = 1'b0,
    KIND_VERDICT = 1'b1
  } kind_e;

  localparam logic [3:0] KW_DEAD  = 4'd15;
  localparam logic [2:0] TAG_DONE = 3'd7;

  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_EQ  = 8'h3D;
  localparam logic [7:0] CH_DOT = 8'h2E;
  localparam logic [7:0] CH_Y   = 8'h79;
  localparam logic [7:0] CH_B   = 8'h62;
  localparam logic [7:0] CH_P   = 8'h70;
  localparam logic [7:0] CH_E   = 8'h65;

  localparam logic [7:0] DATA_OFFSET = 8'd42;
  localparam logic [7:0] ESC_OFFSET  = 8'd106;

  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
  localparam logic [31:0] CNT_MAX  = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [2:0]  idx;
    logic [31:0] val;
    logic        closed;
    logic        bad;
    logic        any;
  } ysd_hunt_t;

  typedef struct packed {
    phase_e      phase;
    lpos_e       lpos;
    logic        esc;
    logic        dot;
    kw_e         kw_kind;
    logic [3:0]  kw_idx;
    ysd_hunt_t   phunt;
    ysd_hunt_t   chunt;
    logic [31:0] crc;
    logic [31:0] count;
  } ysd_state_t;

  localparam ysd_hunt_t HUNT_RESET = '{idx: 3'd0, val: 32'd0, closed: 1'b0,
                                      bad: 1'b0, any: 1'b0};

  localparam ysd_state_t STATE_RESET = '{
    phase: PH_PROLOG, lpos: LP_START, esc: 1'b0, dot: 1'b0,
    kw_kind: KW_NONE, kw_idx: 4'd0, phunt: HUNT_RESET, chunt: HUNT_RESET,
    crc: CRC_INIT, count: 32'd0
  };

  function automatic logic [3:0] kw_len(input kw_e kind);
    logic [3:0] len;
    begin
      unique case (kind)
        KW_BEGIN: len = 4'd8;
        KW_PART:  len = 4'd7;
        KW_END:   len = 4'd5;
        default:  len = 4'd0;
      endcase
      return len;
    end
  endfunction

  // keyword text after "=y" and the first keyword letter
  function automatic logic [7:0] kw_char(input kw_e kind, input logic [3:0] idx);
    logic [7:0] c;
    begin
      c = 8'h00;
      unique case (kind)
        KW_BEGIN: begin
          case (idx)
            4'd3:    c = "e";
            4'd4:    c = "g";
            4'd5:    c = "i";
            4'd6:    c = "n";
            4'd7:    c = " ";
            default: c = 8'h00;
          endcase
        end
        KW_PART: begin
          case (idx)
            4'd3:    c = "a";
            4'd4:    c = "r";
            4'd5:    c = "t";
            4'd6:    c = " ";
            default: c = 8'h00;
          endcase
        end
        KW_END: begin
          case (idx)
            4'd3:    c = "n";
            4'd4:    c = "d";
            default: c = 8'h00;
          endcase
        end
        default: c = 8'h00;
      endcase
      return c;
    end
  endfunction

  // sel 0: "pcrc32=", sel 1: " crc32="
  function automatic logic [7:0] tag_char(input logic sel, input logic [2:0] idx);
    logic [7:0] c;
    begin
      unique case (idx)
        3'd0:    c = sel ? " " : "p";
        3'd1:    c = "c";
        3'd2:    c = "r";
        3'd3:    c = "c";
        3'd4:    c = "3";
        3'd5:    c = "2";
        3'd6:    c = "=";
        default: c = 8'h00;
      endcase
      return c;
    end
  endfunction

  // {valid, value}
  function automatic logic [4:0] hex_digit(input logic [7:0] ch);
    logic [4:0] r;
    logic [7:0] t;
    begin
      r = 5'd0;
      if (ch >= "0" && ch <= "9") begin
        t = ch - 8'h30;
        r = {1'b1, t[3:0]};
      end else if (ch >= "a" && ch <= "f") begin
        t = ch - 8'h57;
        r = {1'b1, t[3:0]};
      end else if (ch >= "A" && ch <= "F") begin
        t = ch - 8'h37;
        r = {1'b1, t[3:0]};
      end
      return r;
    end
  endfunction

  function automatic ysd_hunt_t hunt(input logic sel, input logic [7:0] ch,
                                     input ysd_hunt_t h);
    ysd_hunt_t  n;
    logic [4:0] d;
    begin
      n = h;
      d = hex_digit(ch);
      if (!h.closed) begin
        if (h.idx != TAG_DONE) begin
          if (ch == tag_char(sel, h.idx)) begin
            n.idx = h.idx + 3'd1;
          end else begin
            n.idx = (ch == tag_char(sel, 3'd0)) ? 3'd1 : 3'd0;
          end
        end else if (ch == CH_SP || ch == CH_CR) begin
          n.closed = 1'b1;
          if (!h.any) n.bad = 1'b1;
        end else if (!d[4]) begin
          n.bad    = 1'b1;
          n.closed = 1'b1;
        end else begin
          if (h.val[31:28] != 4'd0) n.bad = 1'b1;
          n.val = {h.val[27:0], d[3:0]};
          n.any = 1'b1;
        end
      end
      return n;
    end
  endfunction

  // reflected CRC-32, one byte
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    begin
      c = crc ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
        c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
    end
  endfunction

endpackage

// ----- sv/yenc_stream_decoder_unit.sv -----
// Path: input register, then result register, from input accept to result valid.
// Throughput: one item per cycle unless a full result register is stalled; the per-byte
//   state update and byte-wise CRC sit in one stage between input and result registers.
// Items that cause no result leave no output item but still wait for a free result register.
// Reset: asynchronous, active low; clears the input register, result valid and kind and all
//   decoder state; result data bits are not reset.
// ----------------------------------------------------------------------------
// yenc_stream_decoder_unit
// Streaming yEnc article decoder with keyword parsing and CRC-32 verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "yenc_stream_decoder_unit_defines.svh"

module yenc_stream_decoder_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] in_byte
  input  logic        s_axis_tuser_i,   // [0] restart
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [79:0] m_axis_tdata_o,   // [7:0] out_byte, [8] crc_match,
                                        // [40:9] computed_crc, [72:41] byte_count
  output logic        m_axis_tuser_o    // [0] kind
);

  logic                in_valid_q;
  logic [7:0]          in_byte_q;
  logic                in_restart_q;
  logic                adv;

  ysd_pkg::ysd_state_t st_q;
  ysd_pkg::ysd_state_t cur;
  ysd_pkg::ysd_state_t nxt;

  logic                res_valid;
  ysd_pkg::kind_e      res_kind;
  logic [7:0]          res_byte;
  logic                res_match;
  logic [31:0]         res_crc;
  logic [31:0]         res_cnt;
  logic                emit_req;
  logic [7:0]          emit_byte;
  logic                skip;
  logic [31:0]         fin;

  logic                out_valid_q;
  ysd_pkg::kind_e      out_kind_q;
  logic [72:0]         out_data_q;

  assign adv             = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || adv;

  always_comb begin
    cur       = in_restart_q ? ysd_pkg::STATE_RESET : st_q;
    nxt       = cur;
    res_valid = 1'b0;
    res_kind  = ysd_pkg::KIND_DATA;
    res_byte  = 8'd0;
    res_match = 1'b0;
    res_crc   = 32'd0;
    res_cnt   = 32'd0;
    emit_req  = 1'b0;
    emit_byte = 8'd0;
    skip      = 1'b0;
    fin       = cur.crc ^ ysd_pkg::CRC_INIT;

    if (cur.phase != ysd_pkg::PH_EPILOG) begin
      if (cur.lpos == ysd_pkg::LP_KEY) begin
        if (in_byte_q == ysd_pkg::CH_LF) begin
          if (cur.kw_kind == ysd_pkg::KW_END &&
              cur.kw_idx == ysd_pkg::kw_len(ysd_pkg::KW_END)) begin
            res_valid = 1'b1;
            res_kind  = ysd_pkg::KIND_VERDICT;
            res_crc   = fin;
            res_cnt   = cur.count;
            if (cur.phunt.idx == ysd_pkg::TAG_DONE) begin
              res_match = cur.phunt.any && !cur.phunt.bad && (cur.phunt.val == fin);
            end else if (cur.chunt.idx == ysd_pkg::TAG_DONE) begin
              res_match = cur.chunt.any && !cur.chunt.bad && (cur.chunt.val == fin);
            end
            nxt.phase = ysd_pkg::PH_EPILOG;
          end
          nxt.lpos    = ysd_pkg::LP_START;
          nxt.kw_kind = ysd_pkg::KW_NONE;
          nxt.kw_idx  = 4'd0;
        end else if (cur.kw_idx == ysd_pkg::KW_DEAD) begin
          nxt.kw_idx = cur.kw_idx;
        end else if (cur.kw_kind == ysd_pkg::KW_NONE) begin
          nxt.kw_idx = 4'd3;
          case (in_byte_q)
            ysd_pkg::CH_B: nxt.kw_kind = ysd_pkg::KW_BEGIN;
            ysd_pkg::CH_P: nxt.kw_kind = ysd_pkg::KW_PART;
            ysd_pkg::CH_E: nxt.kw_kind = ysd_pkg::KW_END;
            default:       nxt.kw_idx  = ysd_pkg::KW_DEAD;
          endcase
        end else if (cur.kw_idx >= ysd_pkg::kw_len(cur.kw_kind)) begin
          if (cur.kw_kind == ysd_pkg::KW_END) begin
            nxt.phunt = ysd_pkg::hunt(1'b0, in_byte_q, cur.phunt);
            nxt.chunt = ysd_pkg::hunt(1'b1, in_byte_q, cur.chunt);
          end
        end else if (in_byte_q != ysd_pkg::kw_char(cur.kw_kind, cur.kw_idx)) begin
          nxt.kw_idx = ysd_pkg::KW_DEAD;
        end else begin
          nxt.kw_idx = cur.kw_idx + 4'd1;
          if (cur.kw_kind == ysd_pkg::KW_BEGIN &&
              nxt.kw_idx == ysd_pkg::kw_len(ysd_pkg::KW_BEGIN) &&
              cur.phase == ysd_pkg::PH_PROLOG) begin
            nxt.phase = ysd_pkg::PH_DATA;
          end
        end
      end else if (cur.lpos == ysd_pkg::LP_EQ) begin
        nxt.esc = 1'b0;
        if (in_byte_q == ysd_pkg::CH_Y) begin
          nxt.lpos    = ysd_pkg::LP_KEY;
          nxt.kw_kind = ysd_pkg::KW_NONE;
          nxt.kw_idx  = 4'd2;
        end else begin
          nxt.lpos  = ysd_pkg::LP_MID;
          emit_req  = 1'b1;
          emit_byte = in_byte_q - ysd_pkg::ESC_OFFSET;
        end
      end else if (cur.esc) begin
        nxt.esc   = 1'b0;
        nxt.dot   = 1'b0;
        nxt.lpos  = ysd_pkg::LP_MID;
        emit_req  = 1'b1;
        emit_byte = in_byte_q - ysd_pkg::ESC_OFFSET;
      end else begin
        if (cur.dot) begin
          nxt.dot = 1'b0;
          if (in_byte_q == ysd_pkg::CH_DOT) begin
            nxt.lpos = ysd_pkg::LP_MID;
            skip     = 1'b1;
          end
        end
        if (!skip) begin
          if (in_byte_q == ysd_pkg::CH_LF) begin
            nxt.lpos = ysd_pkg::LP_START;
          end else if (in_byte_q == ysd_pkg::CH_CR) begin
            nxt.lpos = ysd_pkg::LP_MID;
          end else if (in_byte_q == ysd_pkg::CH_EQ) begin
            nxt.esc  = 1'b1;
            nxt.lpos = (cur.lpos == ysd_pkg::LP_START) ? ysd_pkg::LP_EQ : ysd_pkg::LP_MID;
          end else begin
            if (in_byte_q == ysd_pkg::CH_DOT && cur.lpos == ysd_pkg::LP_START) begin
              nxt.dot = 1'b1;
            end
            nxt.lpos  = ysd_pkg::LP_MID;
            emit_req  = 1'b1;
            emit_byte = in_byte_q - ysd_pkg::DATA_OFFSET;
          end
        end
      end
    end

    // prolog bytes are decoded but dropped
    if (emit_req && cur.phase == ysd_pkg::PH_DATA) begin
      nxt.crc   = ysd_pkg::crc_byte(cur.crc, emit_byte);
      nxt.count = (cur.count != ysd_pkg::CNT_MAX) ? cur.count + 32'd1 : cur.count;
      res_valid = 1'b1;
      res_kind  = ysd_pkg::KIND_DATA;
      res_byte  = emit_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q   <= 1'b0;
      in_byte_q    <= 8'd0;
      in_restart_q <= 1'b0;
      st_q         <= ysd_pkg::STATE_RESET;
      out_valid_q  <= 1'b0;
      out_kind_q   <= ysd_pkg::KIND_DATA;
    end else begin
      if (s_axis_tready_o) begin
        in_valid_q   <= s_axis_tvalid_i;
        in_byte_q    <= s_axis_tdata_i;
        in_restart_q <= s_axis_tuser_i;
      end
      if (adv) begin
        st_q        <= nxt;
        out_valid_q <= res_valid;
        out_kind_q  <= res_kind;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_data_q <= {res_cnt, res_crc, res_match, res_byte};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_kind_q;
  assign m_axis_tdata_o  = {7'd0, out_data_q};

  `YSD_ASSERT_NEXT(a_verdict_ends_part, clk_i, rst_ni,
    adv && res_valid && res_kind == ysd_pkg::KIND_VERDICT, st_q.phase == ysd_pkg::PH_EPILOG)
  `YSD_ASSERT_NEXT(a_epilog_holds, clk_i, rst_ni,
    st_q.phase == ysd_pkg::PH_EPILOG && !(adv && in_restart_q), st_q.phase == ysd_pkg::PH_EPILOG)
  `YSD_ASSERT_IMPLY(a_data_fields_clear, clk_i, rst_ni,
    out_valid_q && out_kind_q == ysd_pkg::KIND_DATA, out_data_q[72:8] == 65'd0)

endmodule

// ----- verif/yenc_stream_decoder_unit_checker.sv -----
// ----------------------------------------------------------------------------
// yenc_stream_decoder_unit_checker
// Watches both stream ports of the yEnc decoder. Every accepted input byte
// runs through an independent decoder model (line state, keyword scan, crc
// value scan, CRC-32 and byte count) and any item it yields is queued. Every
// accepted output item is compared field by field with the oldest queued one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module yenc_stream_decoder_unit_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [7:0]  s_tdata_i,
  input  logic        s_tuser_i,
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [79:0] m_tdata_i,
  input  logic        m_tuser_i,
  output int          fail_count_o,
  output int          pending_o
);

  typedef struct packed {
    logic [2:0]  idx;
    logic [31:0] val;
    logic        closed;
    logic        bad;
    logic        seen;
  } tag_scan_t;

  typedef struct {
    ysd_pkg::kind_e kind;
    logic [7:0]     data;
    logic           match;
    logic [31:0]    crc;
    logic [31:0]    count;
  } dec_result_t;

  ysd_pkg::phase_e ph;
  ysd_pkg::lpos_e  lpos;
  logic            esc_pend;
  logic            dot_pend;
  ysd_pkg::kw_e    kw_kind;
  logic [3:0]      kw_pos;
  tag_scan_t       ptag;
  tag_scan_t       ctag;
  logic [31:0]     run_crc;
  logic [31:0]     dec_count;
  dec_result_t     decoded_q[$];
  int              failures = 0;
  int              waiting = 0;

  assign fail_count_o = failures;
  assign pending_o    = waiting;

  function automatic string keyword_text(input ysd_pkg::kw_e k);
    case (k)
      ysd_pkg::KW_BEGIN: return "=ybegin ";
      ysd_pkg::KW_PART:  return "=ypart ";
      ysd_pkg::KW_END:   return "=yend";
      default:           return "";
    endcase
  endfunction

  function automatic string tag_text(input bit plain_crc);
    if (plain_crc) return " crc32=";
    return "pcrc32=";
  endfunction

  // tag match, then hex value up to space or CR; first value only
  function automatic tag_scan_t scan_tag(input tag_scan_t t, input string tag,
                                         input logic [7:0] ch);
    tag_scan_t  n;
    logic [3:0] nib;
    bit         is_hex;
    n = t;
    if (t.closed) return n;
    if (t.idx != ysd_pkg::TAG_DONE) begin
      if (ch == tag[t.idx]) n.idx = t.idx + 3'd1;
      else n.idx = (ch == tag[0]) ? 3'd1 : 3'd0;
      return n;
    end
    if (ch == ysd_pkg::CH_SP || ch == ysd_pkg::CH_CR) begin
      n.closed = 1'b1;
      if (!t.seen) n.bad = 1'b1;
      return n;
    end
    is_hex = 1'b1;
    nib    = '0;
    if (ch >= "0" && ch <= "9") nib = 4'(ch - "0");
    else if (ch >= "a" && ch <= "f") nib = 4'(ch - "a" + 8'd10);
    else if (ch >= "A" && ch <= "F") nib = 4'(ch - "A" + 8'd10);
    else is_hex = 1'b0;
    if (!is_hex) begin
      n.bad    = 1'b1;
      n.closed = 1'b1;
    end else begin
      if (t.val[31:28] != 4'd0) n.bad = 1'b1;
      n.val  = {t.val[27:0], nib};
      n.seen = 1'b1;
    end
    return n;
  endfunction

  function automatic void clear_decoder();
    ph        = ysd_pkg::PH_PROLOG;
    lpos      = ysd_pkg::LP_START;
    esc_pend  = 1'b0;
    dot_pend  = 1'b0;
    kw_kind   = ysd_pkg::KW_NONE;
    kw_pos    = '0;
    ptag      = '0;
    ctag      = '0;
    run_crc   = ysd_pkg::CRC_INIT;
    dec_count = '0;
  endfunction

  // only the data phase yields bytes and feeds the CRC
  function automatic void push_data(input logic [7:0] b);
    dec_result_t r;
    if (ph != ysd_pkg::PH_DATA) return;
    for (int k = 0; k < 8; k++) begin
      if (run_crc[0] ^ b[k]) run_crc = (run_crc >> 1) ^ ysd_pkg::CRC_POLY;
      else run_crc = run_crc >> 1;
    end
    if (dec_count != ysd_pkg::CNT_MAX) dec_count++;
    r.kind  = ysd_pkg::KIND_DATA;
    r.data  = b;
    r.match = 1'b0;
    r.crc   = '0;
    r.count = '0;
    decoded_q.push_back(r);
  endfunction

  function automatic void decode_byte(input logic [7:0] ch, input logic restart);
    string       kw;
    dec_result_t r;
    logic [31:0] fin;
    if (restart) clear_decoder();
    if (ph == ysd_pkg::PH_EPILOG) return;

    if (lpos == ysd_pkg::LP_KEY) begin
      kw = keyword_text(kw_kind);
      if (ch == ysd_pkg::CH_LF) begin
        if (kw_kind == ysd_pkg::KW_END && kw_pos == kw.len()) begin
          fin     = ~run_crc;
          r.kind  = ysd_pkg::KIND_VERDICT;
          r.data  = '0;
          r.crc   = fin;
          r.count = dec_count;
          if (ptag.idx == ysd_pkg::TAG_DONE)
            r.match = ptag.seen && !ptag.bad && ptag.val == fin;
          else if (ctag.idx == ysd_pkg::TAG_DONE)
            r.match = ctag.seen && !ctag.bad && ctag.val == fin;
          else r.match = 1'b0;
          decoded_q.push_back(r);
          ph = ysd_pkg::PH_EPILOG;
        end
        lpos    = ysd_pkg::LP_START;
        kw_kind = ysd_pkg::KW_NONE;
        kw_pos  = '0;
      end else if (kw_pos == ysd_pkg::KW_DEAD) begin
        // rest of an unknown keyword line
      end else if (kw_kind == ysd_pkg::KW_NONE) begin
        kw_pos = 4'd3;
        case (ch)
          ysd_pkg::CH_B: kw_kind = ysd_pkg::KW_BEGIN;
          ysd_pkg::CH_P: kw_kind = ysd_pkg::KW_PART;
          ysd_pkg::CH_E: kw_kind = ysd_pkg::KW_END;
          default:       kw_pos = ysd_pkg::KW_DEAD;
        endcase
      end else if (kw_pos >= kw.len()) begin
        if (kw_kind == ysd_pkg::KW_END) begin
          ptag = scan_tag(ptag, tag_text(1'b0), ch);
          ctag = scan_tag(ctag, tag_text(1'b1), ch);
        end
      end else if (ch != kw[kw_pos]) begin
        kw_pos = ysd_pkg::KW_DEAD;
      end else begin
        kw_pos++;
        if (kw_kind == ysd_pkg::KW_BEGIN && kw_pos == kw.len() && ph == ysd_pkg::PH_PROLOG)
          ph = ysd_pkg::PH_DATA;
      end
      return;
    end

    if (lpos == ysd_pkg::LP_EQ) begin
      esc_pend = 1'b0;
      if (ch == ysd_pkg::CH_Y) begin
        lpos    = ysd_pkg::LP_KEY;
        kw_kind = ysd_pkg::KW_NONE;
        kw_pos  = 4'd2;
      end else begin
        lpos = ysd_pkg::LP_MID;
        push_data(ch - ysd_pkg::ESC_OFFSET);
      end
      return;
    end

    // escaped byte: CR and LF included
    if (esc_pend) begin
      esc_pend = 1'b0;
      dot_pend = 1'b0;
      lpos     = ysd_pkg::LP_MID;
      push_data(ch - ysd_pkg::ESC_OFFSET);
      return;
    end

    if (dot_pend) begin
      dot_pend = 1'b0;
      if (ch == ysd_pkg::CH_DOT) begin
        lpos = ysd_pkg::LP_MID;
        return;
      end
    end

    case (ch)
      ysd_pkg::CH_LF: lpos = ysd_pkg::LP_START;
      ysd_pkg::CH_CR: lpos = ysd_pkg::LP_MID;
      ysd_pkg::CH_EQ: begin
        esc_pend = 1'b1;
        if (lpos == ysd_pkg::LP_START) lpos = ysd_pkg::LP_EQ;
        else lpos = ysd_pkg::LP_MID;
      end
      default: begin
        if (ch == ysd_pkg::CH_DOT && lpos == ysd_pkg::LP_START) dot_pend = 1'b1;
        lpos = ysd_pkg::LP_MID;
        push_data(ch - ysd_pkg::DATA_OFFSET);
      end
    endcase
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      failures++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    dec_result_t want;
    if (!rst_ni) begin
      clear_decoder();
      decoded_q.delete();
      waiting = 0;
    end else begin
      if (s_tvalid_i && s_tready_i) decode_byte(s_tdata_i, s_tuser_i);
      if (m_tvalid_i && m_tready_i) begin
        if (decoded_q.size() == 0) begin
          $error("output item with none expected: tuser %0h, tdata %0h",
                 m_tuser_i, m_tdata_i);
          failures++;
        end else begin
          want = decoded_q.pop_front();
          check_field("kind", want.kind, m_tuser_i);
          check_field("out_byte", want.data, m_tdata_i[7:0]);
          check_field("crc_match", want.match, m_tdata_i[8]);
          check_field("computed_crc", want.crc, m_tdata_i[40:9]);
          check_field("byte_count", want.count, m_tdata_i[72:41]);
        end
      end
      waiting = decoded_q.size();
    end
  end

endmodule

// ----- verif/yenc_stream_decoder_unit_test.sv -----
// ----------------------------------------------------------------------------
// yenc_stream_decoder_unit_test
// Drives yEnc articles into the decoder: a short directed sequence, then
// random articles (prolog, begin/part lines, escaped and dot-stuffed data,
// end lines with good, wrong, missing and malformed crc values, epilog) mixed
// with noise and cut-off articles. Sender gaps and receiver stalls are random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module yenc_stream_decoder_unit_test;

  localparam int ITEM_TARGET = 700;

  logic        clk_i    = 1'b0;
  logic        rst_ni   = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata  = '0;
  logic        s_tuser  = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [79:0] m_tdata;
  logic        m_tuser;
  int          fails;
  int          pending;

  int          items_sent  = 0;
  int          burst_left  = 0;
  bit          restart_next = 1'b0;
  bit          steady      = 1'b1;
  bit          counting    = 1'b1;
  logic [31:0] art_crc;
  int          art_len;
  int          rx_timer    = 0;
  int          rx_mode     = 0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  yenc_stream_decoder_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser)
  );

  yenc_stream_decoder_unit_checker u_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tvalid_i   (s_tvalid),
    .s_tready_i   (s_tready),
    .s_tdata_i    (s_tdata),
    .s_tuser_i    (s_tuser),
    .m_tvalid_i   (m_tvalid),
    .m_tready_i   (m_tready),
    .m_tdata_i    (m_tdata),
    .m_tuser_i    (m_tuser),
    .fail_count_o (fails),
    .pending_o    (pending)
  );

  // receiver: always ready, random stalls, or long stalls
  always @(posedge clk_i) begin
    if (rx_timer == 0) begin
      rx_mode  <= $urandom_range(0, 2);
      rx_timer <= $urandom_range(30, 200);
    end else begin
      rx_timer <= rx_timer - 1;
    end
    case (rx_mode)
      0:       m_tready <= 1'b1;
      1:       m_tready <= ($urandom_range(0, 9) < 7);
      default: m_tready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  task automatic send_byte(input logic [7:0] b);
    bit took;
    if (!steady && burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    if (burst_left > 0) burst_left--;
    s_tvalid     <= 1'b1;
    s_tdata      <= b;
    s_tuser      <= restart_next;
    restart_next = 1'b0;
    do begin
      @(negedge clk_i);
      took = s_tready;
      @(posedge clk_i);
    end while (!took);
    if (counting) items_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  function automatic logic [31:0] crc_add(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    r = c;
    for (int k = 0; k < 8; k++) begin
      if (r[0] ^ b[k]) r = (r >> 1) ^ ysd_pkg::CRC_POLY;
      else r = r >> 1;
    end
    return r;
  endfunction

  function automatic string hex_text(input logic [31:0] v, input bit upper, input bit trim);
    string      s;
    logic [3:0] nib;
    logic [7:0] c;
    s = "";
    for (int i = 7; i >= 0; i--) begin
      nib = v[i*4 +: 4];
      if (!(trim && s.len() == 0 && nib == 4'd0 && i != 0)) begin
        if (nib < 4'd10) c = "0" + nib;
        else if (upper) c = "A" + nib - 8'd10;
        else c = "a" + nib - 8'd10;
        s = $sformatf("%s%c", s, c);
      end
    end
    return s;
  endfunction

  task automatic send_article();
    int          n;
    logic [7:0]  raw;
    logic [7:0]  enc;
    bit          esc;
    string       s;
    logic [31:0] fin;
    restart_next = 1'b1;
    steady  = ($urandom_range(0, 3) == 0);
    art_crc = ysd_pkg::CRC_INIT;
    art_len = 0;

    // noise and keyword fragments
    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(10, 30)) begin
        case ($urandom_range(0, 12))
          0:       send_byte(ysd_pkg::CH_EQ);
          1:       send_byte(ysd_pkg::CH_Y);
          2:       send_byte(ysd_pkg::CH_LF);
          3:       send_byte(ysd_pkg::CH_CR);
          4:       send_byte(ysd_pkg::CH_DOT);
          5:       send_byte(ysd_pkg::CH_SP);
          6:       send_text("=ybeg");
          7:       send_text("=yend");
          8:       send_text("=ybegin ");
          9:       send_text(" crc32=");
          10:      send_text("=ybegin\r\n");
          default: send_byte(8'($urandom));
        endcase
      end
      return;
    end

    repeat ($urandom_range(0, 2)) begin
      case ($urandom_range(0, 3))
        0:       send_text("..dot\r\n");
        1:       send_text("=yfoo x\n");
        2:       send_text("note\r\n");
        default: send_text("=ypart 9\r\n");
      endcase
    end
    if ($urandom_range(0, 2) == 0) send_text("=ybegin \n");
    else send_text($sformatf("=ybegin size=%0d\r\n", $urandom_range(1, 99)));
    if ($urandom_range(0, 1) == 1) send_text("=ypart begin=1\r\n");

    repeat ($urandom_range(1, 3)) begin
      n = $urandom_range(1, 10);
      for (int i = 0; i < n; i++) begin
        raw = 8'($urandom);
        enc = raw + ysd_pkg::DATA_OFFSET;
        esc = (enc == 8'h00 || enc == ysd_pkg::CH_LF || enc == ysd_pkg::CH_CR ||
               enc == ysd_pkg::CH_EQ || $urandom_range(0, 7) == 0);
        // an escaped 'y' at line start would open a keyword line
        if (i == 0 && enc + 8'd64 == ysd_pkg::CH_Y) esc = 1'b0;
        if (esc) begin
          send_byte(ysd_pkg::CH_EQ);
          send_byte(enc + 8'd64);
        end else if (i == 0 && enc == ysd_pkg::CH_DOT) begin
          send_byte(ysd_pkg::CH_DOT);
          send_byte(ysd_pkg::CH_DOT);
        end else begin
          send_byte(enc);
        end
        art_crc = crc_add(art_crc, raw);
        art_len++;
      end
      if ($urandom_range(0, 1) == 1) send_text("\r\n");
      else send_text("\n");
      if ($urandom_range(0, 7) == 0) begin
        case ($urandom_range(0, 2))
          0:       send_text("=ybegin again\r\n");
          1:       send_text("=ypart 2\r\n");
          default: send_text("=yzz\r\n");
        endcase
      end
    end

    // cut-off article
    if ($urandom_range(0, 9) == 0) return;

    fin = ~art_crc;
    s = $sformatf("=yend size=%0d", art_len);
    case ($urandom_range(0, 7))
      0: s = {s, " pcrc32=", hex_text(fin, 1'b0, 1'b0), " crc32=", hex_text(fin, 1'b0, 1'b0)};
      1: s = {s, " pcrc32=", hex_text(fin ^ (32'd1 << $urandom_range(0, 31)), 1'b0, 1'b0),
              " crc32=", hex_text(fin, 1'b0, 1'b0)};
      2: s = {s, " crc32=", hex_text(fin, 1'b1, 1'b0)};
      3: s = {s, " pcrc32= crc32=", hex_text(fin, 1'b0, 1'b0)};
      4: s = {s, " pcrc32=1", hex_text(fin, 1'b0, 1'b0)};
      5: s = {s, " pcrc32=", hex_text(fin, 1'b0, 1'b0), "g crc32=", hex_text(fin, 1'b0, 1'b0)};
      6: s = s;
      default: begin
        if ($urandom_range(0, 1) == 1) fin = fin ^ 32'h0000_0100;
        s = {s, " pcrc32=", hex_text(fin, 1'b1, 1'b1)};
      end
    endcase
    send_text(s);
    if ($urandom_range(0, 1) == 1) send_text("\r\n");
    else send_text("\n");

    // epilog, ignored by the block
    counting = 1'b0;
    repeat ($urandom_range(0, 3)) send_byte(8'($urandom));
    counting = 1'b1;
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // end line in prolog, then an ignored epilog byte
    restart_next = 1'b1;
    send_text("=yend\n");
    send_byte(ysd_pkg::CH_DOT);
    // minimal begin, byte extremes, escaped LF, dot-stuffed line
    restart_next = 1'b1;
    send_text("=ybegin \n");
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(ysd_pkg::CH_EQ);
    send_byte(ysd_pkg::CH_LF);
    send_text("\n.. ");

    while (items_sent < ITEM_TARGET) send_article();

    s_tvalid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (20) @(posedge clk_i);
    if (fails == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
